/* hw/rtl/fcv_pkg.sv */
// Package: shared types and constants of the full-convolution FIR filter.
package fcv_pkg;

    localparam int MAX_TAPS    = 8;
    localparam int DEFAULT_TAPS = 8;
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int RESP_W      = 34;
    localparam int SUM1_W      = PROD_W + 1;
    localparam int SUM2_W      = PROD_W + 2;
    localparam int SUM3_W      = PROD_W + 3;
    localparam int OFIFO_DEPTH = 8;
    localparam int PTR_W       = $clog2(OFIFO_DEPTH);
    localparam int OCC_W       = $clog2(OFIFO_DEPTH + 1);
    localparam int ADDR_W      = 5;

    typedef logic signed [SAMPLE_W-1:0] fcv_sample_t;
    typedef logic signed [COEF_W-1:0]   fcv_coef_t;
    typedef logic signed [PROD_W-1:0]   fcv_prod_t;

    typedef struct packed {
        logic valid;
        logic final_res;
    } fcv_ctrl_t;

    typedef struct packed {
        logic signed [RESP_W-1:0] response;
        logic                     final_res;
    } fcv_res_t;

endpackage

/* hw/rtl/fcv_cell.sv */
// Tap cell: one delay element and one registered coefficient product.
module fcv_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  fcv_pkg::fcv_sample_t sample_in,
    input  fcv_pkg::fcv_coef_t   coef,
    output fcv_pkg::fcv_sample_t sample_out,
    output fcv_pkg::fcv_prod_t   prod_out
);
    import fcv_pkg::*;

    fcv_sample_t sample_reg;
    fcv_prod_t   prod_reg;
    fcv_prod_t   prod_next;

    assign prod_next = coef * sample_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
        end else if (en) begin
            sample_reg <= sample_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    assign sample_out = sample_reg;
    assign prod_out   = prod_reg;

endmodule

/* hw/rtl/fcv_sum.sv */
// Registered adder tree over the tap products, with output saturation.
module fcv_sum (
    input  logic               aclk,
    input  logic               aresetn,
    input  fcv_pkg::fcv_prod_t prod [fcv_pkg::MAX_TAPS],
    input  fcv_pkg::fcv_ctrl_t ctrl_in,
    output logic               res_valid,
    output fcv_pkg::fcv_res_t  res
);
    import fcv_pkg::*;

    logic signed [SUM1_W-1:0] s1_reg [4];
    logic signed [SUM2_W-1:0] s2_reg [2];
    logic signed [SUM3_W-1:0] s3_reg;
    fcv_ctrl_t                c1_reg;
    fcv_ctrl_t                c2_reg;
    fcv_ctrl_t                c3_reg;

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 4; i++) begin
            s1_reg[i] <= SUM1_W'(prod[2*i]) + SUM1_W'(prod[2*i+1]);
        end
        for (int i = 0; i < 2; i++) begin
            s2_reg[i] <= SUM2_W'(s1_reg[2*i]) + SUM2_W'(s1_reg[2*i+1]);
        end
        s3_reg <= SUM3_W'(s2_reg[0]) + SUM3_W'(s2_reg[1]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
        end else begin
            c1_reg <= ctrl_in;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
        end
    end

    always_comb begin
        if (!s3_reg[SUM3_W-1] && s3_reg[RESP_W-1]) begin
            res.response = {1'b0, {(RESP_W-1){1'b1}}};
        end else begin
            res.response = s3_reg[RESP_W-1:0];
        end
        res.final_res = c3_reg.final_res;
    end

    assign res_valid = c3_reg.valid;

endmodule

/* hw/rtl/fcv_ofifo.sv */
// Output queue: holds results until the receiver takes them.
module fcv_ofifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  fcv_pkg::fcv_res_t wr_data,
    input  logic              rd_en,
    output fcv_pkg::fcv_res_t rd_data,
    output logic              not_empty
);
    import fcv_pkg::*;

    fcv_res_t         mem [OFIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [OCC_W-1:0] cnt_reg;
    logic [OCC_W-1:0] cnt_next;

    always_comb begin
        wr_ptr_next = wr_en ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + OCC_W'(wr_en) - OCC_W'(rd_en);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data   = mem[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);

endmodule

/* hw/rtl/fir_full_convolution_top.sv */
// Top level of the full-convolution FIR filter: control, cell chain, coefficient registers.
//
// Input channel (s_valid/s_ready, s_sample, s_block_end) takes one signed 16-bit sample per
// transfer. Each sample yields one 34-bit result on the output channel (m_valid/m_ready,
// m_response, m_final_res). A sample with s_block_end set is followed by TAPS-1 tail results
// computed from zero samples; the last has m_final_res set (with TAPS = 1 the sample's own
// result carries it). The delay line is then clear for the next block.
// Coefficients coef_0..coef_7 are written over the APB port at byte address 4*i; the user
// must make writes only while no transfer is in flight, as the block does not enforce this.
// Throughput: one sample per cycle while the queue has room; a block end holds s_ready low
// while the tail is issued. The result reaches m_valid through the product register, the
// three-level adder tree and the output queue write. An 8-entry output queue with a credit
// count lets input continue while results wait; when the receiver stalls, s_ready drops once
// the queue and the pipeline hold 8 results. Reset clears the delay line, coefficients, tail
// counter and queue.
module fir_full_convolution_top #(
    parameter int TAPS = fcv_pkg::DEFAULT_TAPS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fcv_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [15:0]            s_sample,
    input  logic                          s_block_end,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [fcv_pkg::RESP_W-1:0] m_response,
    output logic                          m_final_res
);
    import fcv_pkg::*;

    localparam int CNT_W = $clog2(TAPS + 1);

    fcv_coef_t        coef_reg [MAX_TAPS];
    logic [CNT_W-1:0] tail_cnt_reg;
    logic [CNT_W-1:0] tail_cnt_next;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    fcv_ctrl_t        prod_ctrl_reg;
    fcv_ctrl_t        prod_ctrl_next;

    logic             room;
    logic             tail_busy;
    logic             issue;
    logic             accept;
    logic             pop;
    logic             cfg_wr;
    logic [2:0]       cfg_idx;
    fcv_sample_t      chain_sample;
    fcv_sample_t      cell_in  [TAPS];
    fcv_sample_t      cell_out [TAPS];
    fcv_prod_t        prod     [MAX_TAPS];
    logic             res_valid;
    fcv_res_t         res;
    fcv_res_t         head;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = {{(32-COEF_W){coef_reg[cfg_idx][COEF_W-1]}}, coef_reg[cfg_idx]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_TAPS; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (cfg_wr) begin
            coef_reg[cfg_idx] <= pwdata[COEF_W-1:0];
        end
    end

    always_comb begin
        room         = (occ_reg < OCC_W'(OFIFO_DEPTH));
        tail_busy    = (tail_cnt_reg != '0);
        s_ready      = room && !tail_busy;
        accept       = s_valid && s_ready;
        issue        = room && (tail_busy || s_valid);
        pop          = m_valid && m_ready;
        chain_sample = tail_busy ? '0 : s_sample;

        prod_ctrl_next.valid = issue;
        if (tail_busy) begin
            prod_ctrl_next.final_res = (tail_cnt_reg == CNT_W'(1));
        end else begin
            prod_ctrl_next.final_res = s_block_end && (TAPS == 1);
        end

        if (tail_busy && issue) begin
            tail_cnt_next = tail_cnt_reg - CNT_W'(1);
        end else if (accept && s_block_end) begin
            tail_cnt_next = CNT_W'(TAPS - 1);
        end else begin
            tail_cnt_next = tail_cnt_reg;
        end

        occ_next = occ_reg + OCC_W'(issue) - OCC_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tail_cnt_reg  <= '0;
            occ_reg       <= '0;
            prod_ctrl_reg <= '0;
        end else begin
            tail_cnt_reg  <= tail_cnt_next;
            occ_reg       <= occ_next;
            prod_ctrl_reg <= prod_ctrl_next;
        end
    end

    generate
        for (genvar k = 0; k < MAX_TAPS; k++) begin : g_tap
            if (k < TAPS) begin : g_cell
                if (k == 0) begin : g_head
                    assign cell_in[k] = chain_sample;
                end else begin : g_link
                    assign cell_in[k] = cell_out[k-1];
                end
                fcv_cell u_cell (
                    .aclk       (aclk),
                    .aresetn    (aresetn),
                    .en         (issue),
                    .sample_in  (cell_in[k]),
                    .coef       (coef_reg[k]),
                    .sample_out (cell_out[k]),
                    .prod_out   (prod[k])
                );
            end else begin : g_pad
                assign prod[k] = '0;
            end
        end
    endgenerate

    fcv_sum u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .prod      (prod),
        .ctrl_in   (prod_ctrl_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    fcv_ofifo u_ofifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (res_valid),
        .wr_data   (res),
        .rd_en     (pop),
        .rd_data   (head),
        .not_empty (m_valid)
    );

    assign m_response  = head.response;
    assign m_final_res = head.final_res;

endmodule

/* verif/tb_fir_full_convolution_top.sv */
// Testbench for the full-convolution FIR filter: APB coefficient setup, streamed blocks, scoreboard.
module tb_fir_full_convolution_top;
    import fcv_pkg::*;

    localparam int TAPS         = DEFAULT_TAPS;
    localparam int REG_BYTES    = 4;
    localparam int PHASES       = 4;
    localparam int PHASE_ITEMS  = 100;
    localparam int SETTLE_GAP   = 12;
    localparam int LIMIT_CYCLES = 400000;

    class conv_tracker;
        int                 taps;
        logic signed [15:0] coef [MAX_TAPS];
        logic signed [15:0] history [MAX_TAPS];
        fcv_res_t           pending [$];
        int                 errors;
        int                 samples;
        int                 blocks;
        int                 results;

        function new(int n_taps);
            taps = n_taps;
            errors = 0;
            samples = 0;
            blocks = 0;
            results = 0;
            for (int k = 0; k < MAX_TAPS; k++) begin
                coef[k] = '0;
                history[k] = '0;
            end
        endfunction

        function void set_coef(int idx, logic [31:0] value);
            if (idx < MAX_TAPS)
                coef[idx] = value[15:0];
        endfunction

        function logic signed [RESP_W-1:0] shift_in(logic signed [15:0] x);
            longint acc;
            longint sat_max;
            sat_max = (longint'(1) <<< (RESP_W - 1)) - 1;
            acc = longint'(coef[0]) * longint'(x);
            for (int k = 1; k < taps; k++)
                acc += longint'(coef[k]) * longint'(history[k-1]);
            for (int k = taps - 2; k >= 1; k--)
                history[k] = history[k-1];
            if (taps > 1)
                history[0] = x;
            if (acc > sat_max)
                acc = sat_max;
            return acc[RESP_W-1:0];
        endfunction

        function void push(logic signed [RESP_W-1:0] y, logic fin);
            fcv_res_t r;
            r.response = y;
            r.final_res = fin;
            pending.push_back(r);
        endfunction

        function void accept_sample(logic signed [15:0] x, logic block_end);
            samples++;
            push(shift_in(x), block_end && taps <= 1);
            if (block_end) begin
                blocks++;
                for (int t = 1; t < taps; t++)
                    push(shift_in('0), t == taps - 1);
            end
        endfunction

        function void check_response(logic signed [RESP_W-1:0] resp, logic fin);
            fcv_res_t want;
            results++;
            if (pending.size() == 0) begin
                if (errors < 10)
                    $display("unexpected result: response=%0d final_res=%0b", resp, fin);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want.response !== resp || want.final_res !== fin) begin
                if (errors < 10)
                    $display("result %0d wrong: expected response=%0d final_res=%0b, got %0d %0b",
                             results, want.response, want.final_res, resp, fin);
                errors++;
            end
        endfunction
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [ADDR_W-1:0]        paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [15:0]       s_sample = '0;
    logic                     s_block_end = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [RESP_W-1:0] m_response;
    logic                     m_final_res;

    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    logic signed [15:0] next_coef [MAX_TAPS];
    conv_tracker        tracker = new(TAPS);

    fir_full_convolution_top #(.TAPS(TAPS)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .s_block_end (s_block_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_response  (m_response),
        .m_final_res (m_final_res)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_response(m_response, m_final_res);
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_coef(input int idx, input logic signed [15:0] c);
        logic [31:0] value;
        value = {16'($urandom), c};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(REG_BYTES * idx);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        tracker.set_coef(idx, value);
    endtask

    task automatic apply_coefs();
        for (int k = 0; k < MAX_TAPS; k++)
            write_coef(k, next_coef[k]);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_sample(input logic signed [15:0] x, input logic block_end);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid     <= 1'b1;
        s_sample    <= x;
        s_block_end <= block_end;
        do @(posedge aclk); while (!s_ready);
        tracker.accept_sample(x, block_end);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.pending.size() != 0);
        repeat (SETTLE_GAP) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        #(12 * LIMIT_CYCLES);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset coefficients are zero
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);
        settle();

        // saturation: every tap and sample at the negative limit
        for (int k = 0; k < MAX_TAPS; k++)
            next_coef[k] = 16'sh8000;
        apply_coefs();
        for (int i = 0; i < TAPS; i++)
            send_sample(16'sh8000, i == TAPS - 1);
        // flush with no block in progress
        send_sample(16'sh7FFF, 1'b1);
        settle();

        for (int k = 0; k < MAX_TAPS; k++)
            next_coef[k] = 16'sh7FFF;
        apply_coefs();
        for (int i = 0; i < 4; i++)
            send_sample(16'sh7FFF, 1'b0);
        for (int i = 0; i < 4; i++)
            send_sample(16'sh8000, i == 3);
        settle();

        // impulse response exposes each tap
        for (int k = 0; k < MAX_TAPS; k++)
            next_coef[k] = 16'($urandom);
        apply_coefs();
        send_sample(16'sd1, 1'b1);
        send_sample(-16'sd1, 1'b1);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            for (int k = 0; k < MAX_TAPS; k++) begin
                case (p)
                    1: next_coef[k] = 16'sh7FFF;
                    2: next_coef[k] = rand_sample();
                    3: next_coef[k] = (k % 2) ? 16'sh8000 : 16'($urandom);
                    default: next_coef[k] = 16'($urandom);
                endcase
            end
            apply_coefs();
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == PHASE_ITEMS / 2)
                    settle();
                send_sample(rand_sample(), ($urandom_range(11) == 0) || i == PHASE_ITEMS - 1);
            end
            settle();
        end

        $display("Run covered %0d samples in %0d blocks, %0d results checked",
                 tracker.samples, tracker.blocks, tracker.results);
        $display("under extreme, zero and random taps with four sender/receiver idle settings");
        if (tracker.errors == 0 && tracker.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
